// ===== src/shnt_pkg.sv =====
// shared types and constants for the sorted held-note table
// no dependencies; used by shnt_cell and sorted_held_note_table
package shnt_pkg;

	localparam int MAX_NOTES_DEF = 8;

	typedef enum logic [2:0] {
		CMD_INSERT     = 3'd0,
		CMD_DELETE     = 3'd1,
		CMD_PLAY_ALL   = 3'd2,
		CMD_STOP_ALL   = 3'd3,
		CMD_PLAY_INDEX = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_OFF  = 2'd1,
		KIND_ON   = 2'd2
	} kind_t;

	// word address of the channel register
	localparam logic REG_CHANNEL = 1'b0;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] note_number;
		logic [6:0] velocity;
		logic [7:0] index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] event_channel;
		logic [6:0] event_note;
		logic [6:0] event_velocity;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       valid;
		logic       snd;
		logic [6:0] note;
		logic [6:0] vel;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} chain_op_t;

	typedef struct packed {
		chain_op_t  op;
		logic [6:0] key_note;
		logic [6:0] key_vel;
	} chain_ctl_t;

endpackage

// ===== src/sorted_held_note_table.sv =====
// Sorted table of held notes, kept in a row of cells ordered by note number.
// Depends on shnt_pkg and shnt_cell.
//
// Usage: commands arrive on cmd (cmd_valid/cmd_ready), events leave on evt
// (evt_valid/evt_ready). Every item produces one or more events; the final
// one has last set, and an item with nothing to report gives one event of
// kind none. The MIDI channel is written over the APB port at address 0.
// One item is handled at a time: cmd_ready is high only while the
// controller is idle.
// Insert and delete: the item is taken while idle; the execute state then
// updates the cells and loads the event register once that register is free.
// Play all, stop all and play index walk the whole row by rotating it one
// cell per cycle, unless an event waits on a stalled receiver or an entry
// is re-triggered: play all or play index sends a note-off first for a
// sounding entry. A walk that produced nothing ends with a kind-none event.
// A stalled receiver holds the event register and any walk step that emits.
// Reset empties the table, silences all entries and sets the channel to 0.
module sorted_held_note_table #(
	parameter int MAX_NOTES = shnt_pkg::MAX_NOTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  shnt_pkg::in_item_t  cmd,
	output logic                evt_valid,
	input  logic                evt_ready,
	output shnt_pkg::out_item_t evt,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import shnt_pkg::*;

	localparam int N  = MAX_NOTES;
	localparam int SW = (N > 1) ? $clog2(N) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WALK = 4'b0100,
		S_NONE = 4'b1000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	in_item_t   item_q;
	logic [SW-1:0] step_q;
	logic [SW-1:0] step_d;
	logic       phase_q;
	logic       phase_d;
	logic       emitted_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic [3:0] channel_q;

	entry_t     cell_q [N];
	logic       less_w [N];
	logic [N-1:0] valid_vec;
	logic [N-1:0] snd_vec;
	chain_ctl_t chain_ctl;
	entry_t     head_mod;
	entry_t     tail_right;

	logic       can_emit;
	logic       present;
	logic       hit_snd;
	logic       full;
	logic       next_valid;
	logic       at_end;
	logic       is_last_entry;
	logic       act_play;
	logic       do_emit;
	logic       do_rot;
	logic       snd_new;
	kind_t      ev_kind;
	logic [6:0] ev_note;
	logic [6:0] ev_vel;
	logic       ev_last;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHANNEL) ? {28'd0, channel_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= 4'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL) begin
			channel_q <= pwdata[3:0];
		end
	end

	// cell row
	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			entry_t left_e;
			logic   left_l;
			entry_t right_e;
			if (gi == 0) begin : g_first
				assign left_e = '0;
				assign left_l = 1'b1;
			end else begin : g_mid
				assign left_e = cell_q[gi-1];
				assign left_l = less_w[gi-1];
			end
			if (gi == N - 1) begin : g_tail
				assign right_e = tail_right;
			end else begin : g_body
				assign right_e = cell_q[gi+1];
			end
			shnt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (chain_ctl),
				.left      (left_e),
				.left_less (left_l),
				.right     (right_e),
				.tail      ((gi == N - 1) ? 1'b1 : 1'b0),
				.q         (cell_q[gi]),
				.less      (less_w[gi])
			);
			assign valid_vec[gi] = cell_q[gi].valid;
			assign snd_vec[gi]   = cell_q[gi].snd;
		end
		if (N > 1) begin : g_next
			assign next_valid = cell_q[1].valid;
		end else begin : g_no_next
			assign next_valid = 1'b0;
		end
	endgenerate

	// lookups over all cells
	always_comb begin
		present = 1'b0;
		hit_snd = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (cell_q[i].valid && cell_q[i].note == item_q.note_number) begin
				present = 1'b1;
				hit_snd = cell_q[i].snd;
			end
		end
	end

	assign full          = cell_q[N-1].valid;
	assign can_emit      = !out_valid_q || evt_ready;
	assign at_end        = (step_q == SW'(N - 1));
	assign is_last_entry = at_end || !next_valid;
	assign act_play      = (item_q.command == CMD_PLAY_ALL) ||
	                       (item_q.command == CMD_PLAY_INDEX && 8'(step_q) == item_q.index);

	assign head_mod   = '{valid: cell_q[0].valid, snd: snd_new,
	                      note: cell_q[0].note, vel: cell_q[0].vel};
	assign tail_right = (chain_ctl.op == OP_ROTATE) ? head_mod : entry_t'('0);

	// controller
	always_comb begin
		state_d            = state_q;
		step_d             = step_q;
		phase_d            = phase_q;
		do_emit            = 1'b0;
		do_rot             = 1'b0;
		snd_new            = cell_q[0].snd;
		ev_kind            = KIND_NONE;
		ev_note            = 7'd0;
		ev_vel             = 7'd0;
		ev_last            = 1'b1;
		chain_ctl.op       = OP_HOLD;
		chain_ctl.key_note = item_q.note_number;
		chain_ctl.key_vel  = item_q.velocity;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (item_q.command)
					CMD_PLAY_ALL, CMD_STOP_ALL, CMD_PLAY_INDEX: begin
						state_d = S_WALK;
						step_d  = '0;
						phase_d = 1'b0;
					end
					CMD_INSERT: begin
						if (can_emit) begin
							do_emit = 1'b1;
							state_d = S_IDLE;
							if (!present) begin
								chain_ctl.op = OP_INSERT;
								// full table: highest entry falls off the end
								if (full && cell_q[N-1].snd) begin
									ev_kind = KIND_OFF;
									ev_note = cell_q[N-1].note;
								end
							end
						end
					end
					CMD_DELETE: begin
						if (can_emit) begin
							do_emit = 1'b1;
							state_d = S_IDLE;
							if (present) begin
								chain_ctl.op = OP_DELETE;
								if (hit_snd) begin
									ev_kind = KIND_OFF;
									ev_note = item_q.note_number;
								end
							end
						end
					end
					default: begin
						if (can_emit) begin
							do_emit = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_WALK: begin
				// the entry under inspection is always in cell 0
				if (!cell_q[0].valid) begin
					do_rot = 1'b1;
				end else if (item_q.command == CMD_STOP_ALL) begin
					if (can_emit) begin
						do_emit = 1'b1;
						ev_kind = KIND_OFF;
						ev_note = cell_q[0].note;
						ev_last = is_last_entry;
						snd_new = 1'b0;
						do_rot  = 1'b1;
					end
				end else if (act_play) begin
					if (can_emit) begin
						do_emit = 1'b1;
						ev_note = cell_q[0].note;
						if (cell_q[0].snd && !phase_q) begin
							// retrigger: note-off first, stay on this entry
							ev_kind = KIND_OFF;
							ev_last = 1'b0;
							phase_d = 1'b1;
						end else begin
							ev_kind = KIND_ON;
							ev_vel  = cell_q[0].vel;
							ev_last = (item_q.command == CMD_PLAY_INDEX) || is_last_entry;
							snd_new = 1'b1;
							phase_d = 1'b0;
							do_rot  = 1'b1;
						end
					end
				end else begin
					do_rot = 1'b1;
				end
				if (do_rot) begin
					chain_ctl.op = OP_ROTATE;
					if (at_end) begin
						step_d  = '0;
						state_d = (emitted_q || do_emit) ? S_IDLE : S_NONE;
					end else begin
						step_d = step_q + SW'(1);
					end
				end
			end
			S_NONE: begin
				if (can_emit) begin
					do_emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			phase_q     <= 1'b0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			phase_q <= phase_d;
			if (state_q == S_EXEC) begin
				emitted_q <= 1'b0;
			end else if (do_emit) begin
				emitted_q <= 1'b1;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_q <= cmd;
		end
		if (do_emit) begin
			out_q.event_kind     <= ev_kind;
			out_q.event_channel  <= (ev_kind == KIND_NONE) ? 4'd0 : channel_q;
			out_q.event_note     <= ev_note;
			out_q.event_velocity <= ev_vel;
			out_q.last           <= ev_last;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	// outside a walk, occupied cells form one run starting at cell 0
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WALK) |->
		$onehot({1'b0, valid_vec} + {{N{1'b0}}, 1'b1}))
		else $error("table entries not contiguous");

	// an empty cell never sounds
	assert property (@(posedge clk) disable iff (!arst_n)
		(snd_vec & ~valid_vec) == '0)
		else $error("empty cell marked sounding");

	// an insert into a table with room adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(chain_ctl.op == OP_INSERT && !full) |=>
		$countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("insert did not grow table by one");

	// a delete removes exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(chain_ctl.op == OP_DELETE) |=>
		$countones(valid_vec) + 1 == $past($countones(valid_vec)))
		else $error("delete did not shrink table by one");

	// the retrigger phase only exists mid-walk on a sounding head entry
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (state_q == S_WALK && cell_q[0].snd))
		else $error("retrigger phase outside walk");

endmodule

// ===== src/shnt_cell.sv =====
// one table cell: holds a single entry and trades it with its neighbors
// depends on shnt_pkg
module shnt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  shnt_pkg::chain_ctl_t ctl,
	input  shnt_pkg::entry_t    left,
	input  logic                left_less,
	input  shnt_pkg::entry_t    right,
	input  logic                tail,
	output shnt_pkg::entry_t    q,
	output logic                less
);
	import shnt_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   own_less;
	logic   keep_ins;

	assign own_less = entry_q.valid && (entry_q.note < ctl.key_note);
	assign less     = own_less;
	// the tail entry of a full table is dropped on insert
	assign keep_ins = own_less && !tail;
	assign q        = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			OP_INSERT: begin
				if (keep_ins) begin
					entry_d = entry_q;
				end else if (left_less) begin
					entry_d = '{valid: 1'b1, snd: 1'b0, note: ctl.key_note, vel: ctl.key_vel};
				end else begin
					entry_d = left;
				end
			end
			OP_DELETE: begin
				if (!entry_q.valid || entry_q.note >= ctl.key_note) begin
					entry_d = right;
				end
			end
			OP_ROTATE: begin
				entry_d = right;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

endmodule
